[sv/sms_pkg.sv]
package sms_pkg;

  localparam int LIFT_TICKS = 256;
  localparam int LIFT_W     = $clog2(LIFT_TICKS);
  localparam int EASE_DEN   = 100 * LIFT_TICKS;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ARM   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] PUMP_NONE = 2'd0;
  localparam logic [1:0] PUMP_ON   = 2'd1;
  localparam logic [1:0] PUMP_VENT = 2'd2;

  localparam logic [2:0] REG_LIFT_ANGLE       = 3'd0;
  localparam logic [2:0] REG_HIT_OFFSET       = 3'd1;
  localparam logic [2:0] REG_RETURN_TICKS     = 3'd2;
  localparam logic [2:0] REG_HIT_TICKS        = 3'd3;
  localparam logic [2:0] REG_HIT_RETURN_TICKS = 3'd4;
  localparam logic [2:0] REG_CLEAR_TICKS      = 3'd5;

  // (2n-1)*2n for the cosine series terms
  localparam logic [14:1][9:0] TAYLOR_DEN = {
    10'd756, 10'd650, 10'd552, 10'd462, 10'd380, 10'd306, 10'd240,
    10'd182, 10'd132, 10'd90,  10'd56,  10'd30,  10'd12,  10'd2
  };

  typedef logic [LIFT_TICKS-1:0][15:0] ease_rom_t;

  function automatic logic [15:0] ease_q16(int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] c;
    logic signed [63:0] s;
    x    = (64'd314 * 64'(k) * (64'd1 << 28)) / EASE_DEN;
    x2   = (x * x) >> 28;
    term = 64'd1 << 28;
    c    = 64'sd1 <<< 28;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 28) / 64'(TAYLOR_DEN[n]);
      if (n % 2 == 1) begin
        c = c - $signed(term);
      end else begin
        c = c + $signed(term);
      end
    end
    s = (64'sd1 <<< 28) - c + 64'sd4096;
    if (s < 0) begin
      s = 64'sd0;
    end
    s = s >>> 13;
    if (s > 64'sd65535) begin
      s = 64'sd65535;
    end
    return s[15:0];
  endfunction

  function automatic ease_rom_t build_ease_rom();
    ease_rom_t rom;
    for (int k = 0; k < LIFT_TICKS; k++) begin
      rom[k] = ease_q16(k);
    end
    return rom;
  endfunction

  localparam ease_rom_t EASE_ROM = build_ease_rom();

endpackage

[sv/serve_motion_sequencer.sv]
// Serve motion sequencer. Takes tick, arm and start beats and returns one
// result beat per input beat, in order. A beat is registered on entry, then
// decoded against the sequencer state, the eased-lift ROM lookup and the
// 32x16 target multiply, and the result lands in the output register; one
// beat is accepted every cycle while the result side keeps up. The eased
// lift runs for LIFT_TICKS ticks.
module serve_motion_sequencer import sms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_measured_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_stage,
  output logic               out_active,
  output logic signed [31:0] out_aim_angle,
  output logic               out_target_write,
  output logic [1:0]         out_pump_cmd,
  output logic               out_heading_step,
  output logic               out_stop_force,
  output logic               out_output_enable,
  output logic               out_loop_clear,
  output logic               out_done_res
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_LIFT     = 3'd1,
    ST_PUMP_ON  = 3'd2,
    ST_HIT      = 3'd3,
    ST_VENT     = 3'd4,
    ST_CLEAR    = 3'd5
  } stage_t;

  logic signed [31:0] lift_angle_r;
  logic signed [31:0] hit_offset_r;
  logic [15:0]        return_ticks_r;
  logic [15:0]        hit_ticks_r;
  logic [15:0]        hit_return_ticks_r;
  logic [15:0]        clear_ticks_r;

  logic               in_v_r;
  logic [1:0]         op_r;
  logic signed [31:0] meas_r;

  stage_t             stage_r, stage_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic               active_r, active_nxt;
  logic               armed_r, armed_nxt;
  logic signed [31:0] lift_target_r, lift_target_nxt;
  logic signed [31:0] hit_target_r, hit_target_nxt;
  logic               drive_en_r, drive_en_nxt;
  logic signed [31:0] held_r, held_nxt;

  logic               twrite_nxt, hstep_nxt, stopf_nxt, lclear_nxt, done_nxt;
  logic [1:0]         pump_nxt;

  logic               out_v_r;
  logic [2:0]         o_stage_r;
  logic               o_active_r;
  logic signed [31:0] o_target_r;
  logic               o_twrite_r;
  logic [1:0]         o_pump_r;
  logic               o_hstep_r;
  logic               o_stopf_r;
  logic               o_oen_r;
  logic               o_lclear_r;
  logic               o_done_r;

  logic               adv;
  logic               fire;
  logic [15:0]        tick_inc;
  logic signed [32:0] hit_sum;
  logic signed [31:0] hit_sat;
  logic signed [31:0] eased;

  assign adv      = !out_v_r || out_ready;
  assign fire     = in_v_r && adv;
  assign in_ready = !in_v_r || adv;
  assign tick_inc = tick_r + 16'd1;

  assign hit_sum = {lift_angle_r[31], lift_angle_r} + {hit_offset_r[31], hit_offset_r};
  assign hit_sat = (hit_sum[32] != hit_sum[31])
                   ? (hit_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                   : hit_sum[31:0];

  sms_ease u_ease (
    .lift_target  (lift_target_r),
    .tick_idx     (tick_r[LIFT_W-1:0]),
    .eased_target (eased)
  );

  always_comb begin
    stage_nxt       = stage_r;
    tick_nxt        = tick_r;
    active_nxt      = active_r;
    armed_nxt       = armed_r;
    lift_target_nxt = lift_target_r;
    hit_target_nxt  = hit_target_r;
    drive_en_nxt    = drive_en_r;
    held_nxt        = held_r;
    twrite_nxt      = 1'b0;
    hstep_nxt       = 1'b0;
    stopf_nxt       = 1'b0;
    lclear_nxt      = 1'b0;
    done_nxt        = 1'b0;
    pump_nxt        = PUMP_NONE;
    unique case (op_r)
      OP_ARM: begin
        armed_nxt = 1'b1;
      end
      OP_START: begin
        if (armed_r && !active_r) begin
          lift_target_nxt = lift_angle_r;
          hit_target_nxt  = hit_sat;
          active_nxt      = 1'b1;
          armed_nxt       = 1'b0;
          tick_nxt        = 16'd0;
          drive_en_nxt    = 1'b1;
          lclear_nxt      = 1'b1;
          stage_nxt       = ST_LIFT;
        end
      end
      OP_TICK: begin
        if (active_r) begin
          tick_nxt = tick_inc;
          unique case (stage_r)
            ST_LIFT: begin
              held_nxt   = eased;
              twrite_nxt = 1'b1;
              if (tick_inc >= 16'(LIFT_TICKS)) begin
                stage_nxt = ST_PUMP_ON;
                tick_nxt  = 16'd0;
              end
            end
            ST_PUMP_ON: begin
              pump_nxt = PUMP_ON;
              if (tick_inc >= return_ticks_r) begin
                stage_nxt = ST_HIT;
                tick_nxt  = 16'd0;
              end
            end
            ST_HIT: begin
              held_nxt   = hit_target_r;
              twrite_nxt = 1'b1;
              if (tick_inc >= hit_ticks_r) begin
                stage_nxt = ST_VENT;
                tick_nxt  = 16'd0;
              end
            end
            ST_VENT: begin
              pump_nxt = PUMP_VENT;
              if (tick_inc >= hit_return_ticks_r) begin
                stopf_nxt    = 1'b1;
                drive_en_nxt = 1'b0;
                held_nxt     = meas_r;
                twrite_nxt   = 1'b1;
                stage_nxt    = ST_CLEAR;
                tick_nxt     = 16'd0;
              end
            end
            default: begin
              hstep_nxt = 1'b1;
              if (tick_inc >= clear_ticks_r) begin
                stage_nxt  = ST_IDLE;
                tick_nxt   = 16'd0;
                active_nxt = 1'b0;
                done_nxt   = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_angle_r       <= '0;
      hit_offset_r       <= '0;
      return_ticks_r     <= 16'd1;
      hit_ticks_r        <= 16'd1;
      hit_return_ticks_r <= 16'd1;
      clear_ticks_r      <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIFT_ANGLE:       lift_angle_r       <= cfg_wdata;
        REG_HIT_OFFSET:       hit_offset_r       <= cfg_wdata;
        REG_RETURN_TICKS:     return_ticks_r     <= cfg_wdata[15:0];
        REG_HIT_TICKS:        hit_ticks_r        <= cfg_wdata[15:0];
        REG_HIT_RETURN_TICKS: hit_return_ticks_r <= cfg_wdata[15:0];
        REG_CLEAR_TICKS:      clear_ticks_r      <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      op_r   <= in_opcode;
      meas_r <= in_measured_angle;
    end
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r       <= ST_IDLE;
      tick_r        <= '0;
      active_r      <= 1'b0;
      armed_r       <= 1'b1;
      lift_target_r <= '0;
      hit_target_r  <= '0;
      drive_en_r    <= 1'b1;
      held_r        <= '0;
      out_v_r       <= 1'b0;
    end else if (fire) begin
      stage_r       <= stage_nxt;
      tick_r        <= tick_nxt;
      active_r      <= active_nxt;
      armed_r       <= armed_nxt;
      lift_target_r <= lift_target_nxt;
      hit_target_r  <= hit_target_nxt;
      drive_en_r    <= drive_en_nxt;
      held_r        <= held_nxt;
      out_v_r       <= 1'b1;
    end else if (out_ready) begin
      out_v_r       <= 1'b0;
    end
    if (fire) begin
      o_stage_r  <= stage_nxt;
      o_active_r <= active_nxt;
      o_target_r <= held_nxt;
      o_twrite_r <= twrite_nxt;
      o_pump_r   <= pump_nxt;
      o_hstep_r  <= hstep_nxt;
      o_stopf_r  <= stopf_nxt;
      o_oen_r    <= drive_en_nxt;
      o_lclear_r <= lclear_nxt;
      o_done_r   <= done_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_stage         = o_stage_r;
  assign out_active        = o_active_r;
  assign out_aim_angle     = o_target_r;
  assign out_target_write  = o_twrite_r;
  assign out_pump_cmd      = o_pump_r;
  assign out_heading_step  = o_hstep_r;
  assign out_stop_force    = o_stopf_r;
  assign out_output_enable = o_oen_r;
  assign out_loop_clear    = o_lclear_r;
  assign out_done_res      = o_done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_done_r) |-> (o_stage_r == ST_IDLE && !o_active_r))
    else $error("done beat while not idle");

  a_stop_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_stopf_r) |-> (!o_oen_r && o_twrite_r && o_stage_r == ST_CLEAR))
    else $error("force stop without drive off and target write");

  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("processed beat did not reach output");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!active_r) |-> (stage_r == ST_IDLE))
    else $error("stage advanced while inactive");

endmodule

[sv/sms_ease.sv]
module sms_ease import sms_pkg::*; (
  input  logic signed [31:0] lift_target,
  input  logic [LIFT_W-1:0]  tick_idx,
  output logic signed [31:0] eased_target
);

  logic [15:0]        ease;
  logic signed [48:0] prod;
  logic signed [48:0] rnd;

  assign ease         = EASE_ROM[tick_idx];
  assign prod         = 49'(lift_target) * $signed({33'd0, ease});
  assign rnd          = prod + 49'sd32768;
  assign eased_target = rnd[47:16];

endmodule
